// File: rtl/indexed_shift_list_core_assert.svh
// Assertion macros shared by the list core.
// All checks sample on the rising edge of clk and stay quiet while rst_n is low.
`ifndef INDEXED_SHIFT_LIST_CORE_ASSERT_SVH
`define INDEXED_SHIFT_LIST_CORE_ASSERT_SVH

// Same-cycle implication.
`define ISL_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("list core check failed");

// Next-cycle implication.
`define ISL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("list core sequencing check failed");

`endif

// File: rtl/isl_pkg.sv
package isl_pkg;

  localparam int CAPACITY = 16;
  localparam int WORD_W   = 32;
  localparam int POS_W    = 5;
  localparam int CNT_W    = 5;
  localparam int IDX_W    = 4;

  typedef enum logic [2:0] {
    OP_APPEND = 3'd0,
    OP_READ   = 3'd1,
    OP_WRITE  = 3'd2,
    OP_INSERT = 3'd3,
    OP_REMOVE = 3'd4,
    OP_FIND   = 3'd5,
    OP_CLEAR  = 3'd6
  } op_t;

  // Per-cell update selection.
  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_LOAD = 2'd1,
    CELL_PREV = 2'd2,
    CELL_NEXT = 2'd3
  } cell_mode_t;

  typedef struct packed {
    logic [2:0]        operation;
    logic [POS_W-1:0]  position;
    logic [WORD_W-1:0] word_in;
  } in_t;

  typedef struct packed {
    logic              status;
    logic [WORD_W-1:0] word_out;
    logic              found;
    logic [IDX_W-1:0]  found_position;
    logic [CNT_W-1:0]  count;
    logic              empty_res;
  } out_t;

endpackage

// File: rtl/indexed_shift_list_core.sv
// Channel   | Ports                   | Handshake
// ----------+-------------------------+-------------------------------------------
// request   | start, busy, in_req     | taken on a rising edge with start=1, busy=0
// result    | out_valid, out_res      | one-cycle strobe, no back-pressure
//
// One request per clock while busy is low: the row of 16 cells shifts, loads and compares in the
// cycle the request is taken, and the result strobes in the following cycle.
// The result is held in the result register; cells and count settle together.
// Synchronous active-low reset empties the list and holds busy high through reset
// until the first edge with rst_n high; cell contents are not cleared (entries past the
// count are never read). The receiver cannot stall, so busy never rises after reset.
module indexed_shift_list_core (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  isl_pkg::in_t  in_req,
  output logic          out_valid,
  output isl_pkg::out_t out_res
);

  localparam int CAP  = isl_pkg::CAPACITY;
  localparam int WW   = isl_pkg::WORD_W;
  localparam int CW   = isl_pkg::CNT_W;
  localparam int IW   = isl_pkg::IDX_W;

  logic                busy_r;
  logic [CW-1:0]       count_r;
  logic [CW-1:0]       count_nxt;
  logic                out_valid_r;
  isl_pkg::out_t       out_r;
  isl_pkg::out_t       out_nxt;

  logic                accept;
  isl_pkg::op_t        op;
  logic [CW-1:0]       pos;
  logic [WW-1:0]       key;
  logic                key_nz;
  logic                pos_ok;
  logic                has_room;

  isl_pkg::cell_mode_t mode   [CAP];
  logic [WW-1:0]       data   [CAP];
  logic                hit    [CAP];

  logic [WW-1:0]       rd_data;
  logic                find_hit;
  logic [IW-1:0]       find_pos;

  assign accept   = start & ~busy_r;
  assign op       = isl_pkg::op_t'(in_req.operation);
  assign pos      = in_req.position;
  assign key      = in_req.word_in;
  assign key_nz   = |key;
  assign pos_ok   = (pos < count_r);
  assign has_room = (count_r < CW'(CAP));

  // Cell row: each cell takes its left or right neighbor when the list shifts.
  for (genvar g = 0; g < CAP; g++) begin : g_cell
    logic [WW-1:0] prev_w;
    logic [WW-1:0] next_w;
    if (g == 0) begin : g_first
      assign prev_w = key;
    end else begin : g_mid_p
      assign prev_w = data[g-1];
    end
    if (g == CAP - 1) begin : g_last
      assign next_w = data[g];
    end else begin : g_mid_n
      assign next_w = data[g+1];
    end
    isl_cell u_cell (
      .clk       (clk),
      .mode      (mode[g]),
      .load_word (key),
      .prev_word (prev_w),
      .next_word (next_w),
      .key       (key),
      .data      (data[g]),
      .hit       (hit[g])
    );
  end

  // Per-cell decode: every cell looks at its own index against position and count.
  always_comb begin
    for (int i = 0; i < CAP; i++) begin
      mode[i] = isl_pkg::CELL_HOLD;
      if (accept) begin
        unique case (op)
          isl_pkg::OP_APPEND: begin
            if (key_nz && has_room && count_r == CW'(i)) mode[i] = isl_pkg::CELL_LOAD;
          end
          isl_pkg::OP_WRITE: begin
            if (key_nz && pos_ok && pos == CW'(i)) mode[i] = isl_pkg::CELL_LOAD;
          end
          isl_pkg::OP_INSERT: begin
            if (key_nz && has_room && pos <= count_r) begin
              if (pos == CW'(i)) begin
                mode[i] = isl_pkg::CELL_LOAD;
              end else if (CW'(i) > pos && CW'(i) <= count_r) begin
                mode[i] = isl_pkg::CELL_PREV;
              end
            end
          end
          isl_pkg::OP_REMOVE: begin
            if (pos_ok && CW'(i) >= pos && (CW'(i) + 1'b1) < count_r) begin
              mode[i] = isl_pkg::CELL_NEXT;
            end
          end
          default: mode[i] = isl_pkg::CELL_HOLD;
        endcase
      end
    end
  end

  // Pick the addressed entry and the lowest matching live entry.
  always_comb begin
    rd_data  = '0;
    find_hit = 1'b0;
    find_pos = '0;
    for (int i = 0; i < CAP; i++) begin
      if (pos == CW'(i)) rd_data = rd_data | data[i];
    end
    for (int i = CAP - 1; i >= 0; i--) begin
      if (hit[i] && CW'(i) < count_r) begin
        find_hit = 1'b1;
        find_pos = IW'(i);
      end
    end
  end

  // Result and next count for the request on the ports.
  always_comb begin
    count_nxt              = count_r;
    out_nxt                = '0;
    out_nxt.status         = 1'b1;
    unique case (op)
      isl_pkg::OP_APPEND: begin
        if (key_nz && has_room) begin
          count_nxt      = count_r + 1'b1;
          out_nxt.status = 1'b0;
        end
      end
      isl_pkg::OP_READ: begin
        if (pos_ok) begin
          out_nxt.word_out = rd_data;
          out_nxt.status   = 1'b0;
        end
      end
      isl_pkg::OP_WRITE: begin
        if (key_nz && pos_ok) out_nxt.status = 1'b0;
      end
      isl_pkg::OP_INSERT: begin
        if (key_nz && has_room && pos <= count_r) begin
          count_nxt      = count_r + 1'b1;
          out_nxt.status = 1'b0;
        end
      end
      isl_pkg::OP_REMOVE: begin
        if (pos_ok) begin
          count_nxt        = count_r - 1'b1;
          out_nxt.word_out = rd_data;
          out_nxt.status   = 1'b0;
        end
      end
      isl_pkg::OP_FIND: begin
        if (key_nz) begin
          out_nxt.status         = 1'b0;
          out_nxt.found          = find_hit;
          out_nxt.found_position = find_pos;
        end
      end
      isl_pkg::OP_CLEAR: begin
        count_nxt      = '0;
        out_nxt.status = 1'b0;
      end
      default: out_nxt.status = 1'b1;
    endcase
    out_nxt.count     = count_nxt;
    out_nxt.empty_res = (count_nxt == '0);
  end

  // Control state: hold busy through reset, advance count and strobe on a request.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b1;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= 1'b0;
      out_valid_r <= accept;
      if (accept) count_r <= count_nxt;
    end
  end

  // Result payload: load only when a request is taken.
  always_ff @(posedge clk) begin
    if (accept) out_r <= out_nxt;
  end

  assign busy      = busy_r;
  assign out_valid = out_valid_r;
  assign out_res   = out_r;

`include "indexed_shift_list_core_assert.svh"

  `ISL_ASSERT_NOW(a_count_cap, 1'b1, count_r <= CW'(CAP))
  `ISL_ASSERT_NEXT(a_strobe_follows, accept, out_valid_r)
  `ISL_ASSERT_NOW(a_err_keeps_count, out_valid_r && out_r.status, count_r == $past(count_r))
  `ISL_ASSERT_NOW(a_found_live, out_valid_r && out_r.found,
                  !out_r.status && CW'(out_r.found_position) < count_r)
  `ISL_ASSERT_NOW(a_idle_count, !$past(accept), count_r == $past(count_r))

endmodule

// File: rtl/isl_cell.sv
module isl_cell (
  input  logic                         clk,
  input  isl_pkg::cell_mode_t          mode,
  input  logic [isl_pkg::WORD_W-1:0]   load_word,
  input  logic [isl_pkg::WORD_W-1:0]   prev_word,
  input  logic [isl_pkg::WORD_W-1:0]   next_word,
  input  logic [isl_pkg::WORD_W-1:0]   key,
  output logic [isl_pkg::WORD_W-1:0]   data,
  output logic                         hit
);

  logic [isl_pkg::WORD_W-1:0] data_r;
  logic [isl_pkg::WORD_W-1:0] data_nxt;

  always_comb begin
    unique case (mode)
      isl_pkg::CELL_LOAD: data_nxt = load_word;
      isl_pkg::CELL_PREV: data_nxt = prev_word;
      isl_pkg::CELL_NEXT: data_nxt = next_word;
      default:            data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;
  assign hit  = (data_r == key);

endmodule
